FILE: sv/plq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plq_pkg: shared types and constants for the priority lock queue
// Word layouts for the command and result ports, the per-cell control
// word and the status codes.
// ----------------------------------------------------------------------------
package plq_pkg;

    localparam int Q_DEPTH = 16;
    localparam int CNT_W   = $clog2(Q_DEPTH + 1);
    localparam int ID_W    = 4;
    localparam int PRI_W   = 8;

    typedef enum logic {
        CMD_ACQUIRE = 1'b0,
        CMD_RELEASE = 1'b1
    } t_cmd;

    typedef enum logic [2:0] {
        ST_GRANTED = 3'd0,
        ST_QUEUED  = 3'd1,
        ST_DROPPED = 3'd2,
        ST_HANDED  = 3'd3,
        ST_FREED   = 3'd4
    } t_status;

    typedef struct packed {
        t_cmd              command;
        logic [ID_W-1:0]   requester_id;
        logic [PRI_W-1:0]  priority_req;
    } t_req;

    typedef struct packed {
        t_status           status;
        logic              grant_valid;
        logic [ID_W-1:0]   grant_id;
        logic [CNT_W-1:0]  waiting_count;
        logic              lock_held;
    } t_rsp;

    // broadcast to every cell in the chain
    typedef struct packed {
        logic              ins;
        logic              pop;
        logic [PRI_W-1:0]  pri;
        logic [ID_W-1:0]   id;
    } t_cell_ctrl;

endpackage

FILE: sv/plq_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plq_cell: one slot of the sorted wait queue
// Holds one waiter; on insert it keeps, takes the new word or takes its
// left neighbor; on pop it takes its right neighbor.
// ----------------------------------------------------------------------------
module plq_cell (
    input  logic                        i_clk,
    input  plq_pkg::t_cell_ctrl         i_ctrl,
    input  logic                        i_occ,
    input  logic                        i_left_le,
    input  logic [plq_pkg::PRI_W-1:0]   i_left_pri,
    input  logic [plq_pkg::ID_W-1:0]    i_left_id,
    input  logic [plq_pkg::PRI_W-1:0]   i_right_pri,
    input  logic [plq_pkg::ID_W-1:0]    i_right_id,
    output logic                        o_le,
    output logic [plq_pkg::PRI_W-1:0]   o_pri,
    output logic [plq_pkg::ID_W-1:0]    o_id
);
    import plq_pkg::*;

    logic [PRI_W-1:0] r_pri, n_pri;
    logic [ID_W-1:0]  r_id,  n_id;

    // occupied and served no later than the new request
    assign o_le  = i_occ && (r_pri <= i_ctrl.pri);
    assign o_pri = r_pri;
    assign o_id  = r_id;

    always_comb begin
        n_pri = r_pri;
        n_id  = r_id;
        if (i_ctrl.pop) begin
            n_pri = i_right_pri;
            n_id  = i_right_id;
        end else if (i_ctrl.ins && !o_le) begin
            if (i_left_le) begin
                n_pri = i_ctrl.pri;
                n_id  = i_ctrl.id;
            end else begin
                n_pri = i_left_pri;
                n_id  = i_left_id;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_pri <= n_pri;
        r_id  <= n_id;
    end

endmodule

FILE: sv/priority_lock_queue_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// priority_lock_queue_core: lock with a priority-sorted wait queue
// Acquire grants a free lock, inserts into a chain of sorted cells or is dropped when full;
// release hands the lock to the head cell or frees it.
// ----------------------------------------------------------------------------
//  channel   ports                     handshake
//  command   i_start, i_req            taken when i_start and !o_busy
//  result    o_done, o_rsp             one-cycle strobe, no back-pressure
//
//  One command per cycle: the cell chain shifts, inserts or pops in the
//  cycle the command is taken, so o_busy stays low.
//  The result appears on o_rsp in the cycle after the command is taken.
//  Synchronous active-low reset frees the lock and empties the queue; no
//  clearing pass is needed. The receiver cannot stall.
// ----------------------------------------------------------------------------
module priority_lock_queue_core (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  plq_pkg::t_req   i_req,
    output logic            o_busy,
    output logic            o_done,
    output plq_pkg::t_rsp   o_rsp
);
    import plq_pkg::*;

    logic              r_held, n_held;
    logic [CNT_W-1:0]  r_count, n_count;
    logic              r_done;
    t_rsp              r_rsp, n_rsp;
    logic              accept;
    logic              full;
    t_cell_ctrl        ctrl;

    logic [Q_DEPTH-1:0] occ;
    logic [Q_DEPTH-1:0] le;
    logic [PRI_W-1:0]   pri [Q_DEPTH];
    logic [ID_W-1:0]    id  [Q_DEPTH];

    assign accept = i_start && !o_busy;
    assign full   = (r_count == CNT_W'(Q_DEPTH));
    assign o_busy = 1'b0;

    always_comb begin
        ctrl.ins = accept && (i_req.command == CMD_ACQUIRE) && r_held && !full;
        ctrl.pop = accept && (i_req.command == CMD_RELEASE) && (r_count != '0);
        ctrl.pri = i_req.priority_req;
        ctrl.id  = i_req.requester_id;
    end

    genvar g;
    generate
        for (g = 0; g < Q_DEPTH; g++) begin : g_cell
            logic             left_le;
            logic [PRI_W-1:0] left_pri, right_pri;
            logic [ID_W-1:0]  left_id, right_id;

            assign occ[g] = (r_count > CNT_W'(g));

            if (g == 0) begin : g_first
                assign left_le  = 1'b1;
                assign left_pri = '0;
                assign left_id  = '0;
            end else begin : g_mid
                assign left_le  = le[g-1];
                assign left_pri = pri[g-1];
                assign left_id  = id[g-1];
            end

            if (g == Q_DEPTH - 1) begin : g_last
                assign right_pri = '0;
                assign right_id  = '0;
            end else begin : g_inner
                assign right_pri = pri[g+1];
                assign right_id  = id[g+1];
            end

            plq_cell u_cell (
                .i_clk       (i_clk),
                .i_ctrl      (ctrl),
                .i_occ       (occ[g]),
                .i_left_le   (left_le),
                .i_left_pri  (left_pri),
                .i_left_id   (left_id),
                .i_right_pri (right_pri),
                .i_right_id  (right_id),
                .o_le        (le[g]),
                .o_pri       (pri[g]),
                .o_id        (id[g])
            );
        end
    endgenerate

    // next lock state and result word
    always_comb begin
        n_held  = r_held;
        n_count = r_count;
        n_rsp   = r_rsp;
        if (accept) begin
            n_rsp.grant_valid = 1'b0;
            n_rsp.grant_id    = '0;
            if (i_req.command == CMD_ACQUIRE) begin
                if (!r_held) begin
                    n_held            = 1'b1;
                    n_rsp.status      = ST_GRANTED;
                    n_rsp.grant_valid = 1'b1;
                    n_rsp.grant_id    = i_req.requester_id;
                end else if (full) begin
                    n_rsp.status = ST_DROPPED;
                end else begin
                    n_count      = r_count + CNT_W'(1);
                    n_rsp.status = ST_QUEUED;
                end
            end else begin
                if (r_count == '0) begin
                    n_held       = 1'b0;
                    n_rsp.status = ST_FREED;
                end else begin
                    n_count           = r_count - CNT_W'(1);
                    n_rsp.status      = ST_HANDED;
                    n_rsp.grant_valid = 1'b1;
                    n_rsp.grant_id    = id[0];
                end
            end
            n_rsp.waiting_count = n_count;
            n_rsp.lock_held     = n_held;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held  <= 1'b0;
            r_count <= '0;
            r_done  <= 1'b0;
        end else begin
            r_held  <= n_held;
            r_count <= n_count;
            r_done  <= accept;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rsp <= n_rsp;
    end

    assign o_done = r_done;
    assign o_rsp  = r_rsp;

endmodule
